FILE: hdl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Types and codes shared by the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // Codes carried in the mode field of a request.
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // One request item.
    typedef struct packed {
        logic               mode;
        logic [15:0]        entry_index;
        logic signed [31:0] value;
        logic [15:0]        range_low;
        logic [15:0]        range_high;
    } t_req;

    // One result item.
    typedef struct packed {
        logic        found;
        logic [15:0] position;
    } t_rsp;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_CMP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic wr;
        logic probe;
        logic step;
        logic done_hit;
        logic done_miss;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic hit;
    } t_dp_stat;

endpackage

FILE: hdl/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 65536,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read of the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller: issues table writes and sequences the probe and compare steps of one search.
// ----------------------------------------------------------------------------
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_mode,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd,
    output logic      o_busy
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode == MODE_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_ADDR;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_ADDR: begin
                // An empty range ends the search without a match.
                if (i_stat.empty) begin
                    o_cmd.done_miss = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.done_hit = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_ADDR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    // A read is always followed by its compare.
    a_probe_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.probe |=> (r_state == S_CMP))
        else $error("probe not followed by compare");

    // A finished search frees the block in the next cycle.
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.done_hit || o_cmd.done_miss) |=> !o_busy)
        else $error("busy after search end");

endmodule

FILE: hdl/stbs_dp.sv
// ----------------------------------------------------------------------------
// stbs_dp
// Datapath: table RAM, search bounds, key, compare and result register.
// ----------------------------------------------------------------------------
module stbs_dp
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 65536,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_cmd i_cmd,
    input  t_req      i_req,
    output t_dp_stat  o_stat,
    output logic      o_done,
    output t_rsp      o_rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = (AW > 16) ? AW : 16;

    logic signed [17:0]            r_low;
    logic signed [17:0]            r_high;
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic [15:0]                   r_mid;
    logic                          r_oob;
    logic                          r_valid;
    logic                          r_found;
    logic [15:0]                   r_position;

    logic signed [17:0]            w_diff;
    logic signed [17:0]            w_mid;
    logic signed [17:0]            w_mid_reg;
    logic [15:0]                   w_mid16;
    logic [IW-1:0]                 w_wr_ext;
    logic [IW-1:0]                 w_rd_ext;
    logic [AW-1:0]                 w_addr;
    logic                          w_we;
    logic signed [VALUE_WIDTH-1:0] w_wdata;
    logic [VALUE_WIDTH-1:0]        w_rdata;
    logic signed [VALUE_WIDTH-1:0] w_probe;

    // Midpoint of the current range; the difference is never negative here.
    assign w_diff    = r_high - r_low;
    assign w_mid     = r_low + (w_diff >>> 1);
    assign w_mid16   = w_mid[15:0];
    assign w_mid_reg = signed'({2'b00, r_mid});

    // Index to RAM address, writes beyond the table are dropped.
    assign w_wr_ext = IW'(i_req.entry_index);
    assign w_rd_ext = IW'(w_mid16);
    assign w_addr   = i_cmd.wr ? w_wr_ext[AW-1:0] : w_rd_ext[AW-1:0];
    assign w_we     = i_cmd.wr && (32'(i_req.entry_index) < 32'(TABLE_DEPTH));
    assign w_wdata  = VALUE_WIDTH'(i_req.value);

    stbs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // A probe beyond the table reads as zero.
    assign w_probe = r_oob ? '0 : signed'(w_rdata);

    assign o_stat.empty = (r_low > r_high);
    assign o_stat.hit   = (w_probe == r_key);

    // Bounds, key and probe index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_low  <= signed'({2'b00, i_req.range_low});
            r_high <= signed'({2'b00, i_req.range_high});
            r_key  <= VALUE_WIDTH'(i_req.value);
        end else if (i_cmd.step) begin
            if (w_probe < r_key) begin
                r_low <= w_mid_reg + 18'sd1;
            end else begin
                r_high <= w_mid_reg - 18'sd1;
            end
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid16;
            r_oob <= !(32'(w_mid16) < 32'(TABLE_DEPTH));
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.done_hit || i_cmd.done_miss;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.done_hit || i_cmd.done_miss) begin
            r_found    <= i_cmd.done_hit;
            r_position <= i_cmd.done_hit ? r_mid : 16'd0;
        end
    end

    assign o_done       = r_valid;
    assign o_rsp.found    = r_found;
    assign o_rsp.position = r_position;

    // Two searches cannot finish in back-to-back cycles.
    a_no_double_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe in consecutive cycles");

    // A miss always reports position zero.
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_found) |-> (r_position == 16'd0))
        else $error("miss with nonzero position");

endmodule

FILE: hdl/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Binary search over a table of signed entries held in an on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers at a rising edge where start is high and busy is low.
//   Mode write stores value at entry_index; busy stays low and no result
//   follows. Writes beyond the table are dropped.
//   Mode search looks for value in range_low..range_high, which should hold
//   ascending, already written entries. Busy rises after the transfer and
//   falls in the cycle the result appears.
//   Each probe first issues the read at the midpoint and then compares the
//   registered RAM output with the key. A search over 65536 entries takes
//   at most 17 probes. The result transfers on o_rsp during the single
//   cycle that o_done is high; the receiver cannot stall it. An empty
//   starting range gives a miss. A miss reports position zero.
//   Synchronous reset returns the controller to idle; table contents are
//   kept and are undefined after power-up until written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 65536,
    parameter int VALUE_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    // Search sequencer.
    stbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_req.mode),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Table, bounds and result.
    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_stat  (w_stat),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule
